// ===== src/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// smq_pkg
// Shared types, codes and sizes for the sorted event merge queue.
// ----------------------------------------------------------------------------
`default_nettype none

package smq_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TIME_W = 31;
    localparam int CODE_W = 10;
    localparam int CHAN_W = 6;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD    = 2'd0;
    localparam op_t OP_INSERT  = 2'd1;
    localparam op_t OP_REMOVE  = 2'd2;
    localparam op_t OP_REPLACE = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic [CODE_W-1:0] event_code;
        logic [CHAN_W-1:0] channel;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        op_t    op;
        entry_t entry;
    } bcast_t;

endpackage

`default_nettype wire

// ===== src/sorted_event_merge_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_event_merge_queue
// Priority queue that merges per-channel sorted event streams by (time, code).
// ----------------------------------------------------------------------------
// Input requests (s_*): insert an entry, pop the head and reinsert it with a
// new time, or pop the head and drop it. Each request gives exactly one
// result (m_*): the popped entry when head_valid is set, a status (ok, insert
// dropped on a full queue, pop on an empty queue) and the occupancy after the
// request.
// The list is a row of DEPTH cells, kept sorted with the head in cell 0. Every
// cell compares its entry with the broadcast key in parallel and shifts toward
// or away from its neighbor, so a request finishes in the cycle it is
// accepted. The result is registered: it shows in the cycle after acceptance,
// and one request per cycle is sustained while m_ready stays high.
// When the receiver stalls, the result register holds and s_ready drops until
// the result is taken.
// Reset (aresetn low, synchronous) empties the queue at once and drops any
// pending result; no clearing pass runs and entry contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_event_merge_queue
    import smq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [KIND_W-1:0] s_kind,
    input  wire logic [TIME_W-1:0] s_event_time,
    input  wire logic [CODE_W-1:0] s_event_code,
    input  wire logic [CHAN_W-1:0] s_channel,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_head_valid,
    output logic [TIME_W-1:0]      m_out_time,
    output logic [CODE_W-1:0]      m_out_code,
    output logic [CHAN_W-1:0]      m_out_channel,
    output logic [STAT_W-1:0]      m_status,
    output logic [CNT_W-1:0]       m_occupancy
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic             head_valid_reg, head_valid_next;
    entry_t           out_entry_reg, out_entry_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic   accept;
    logic   q_empty, q_full;
    bcast_t bcast;
    entry_t cell_entry [DEPTH];
    logic   cell_lt    [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        bcast.op               = OP_HOLD;
        bcast.entry.event_time = s_event_time;
        bcast.entry.event_code = s_event_code;
        bcast.entry.channel    = s_channel;
        count_next             = count_reg;
        head_valid_next        = 1'b0;
        out_entry_next         = '0;
        status_next            = ST_OK;
        if (s_kind == KIND_REPLACE) begin
            bcast.entry.event_code = cell_entry[0].event_code;
            bcast.entry.channel    = cell_entry[0].channel;
        end
        case (s_kind) inside
            KIND_INSERT: begin
                if (q_full) begin
                    status_next = ST_FULL;
                end else begin
                    bcast.op   = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REPLACE, KIND_REMOVE: begin
                if (q_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    head_valid_next = 1'b1;
                    out_entry_next  = cell_entry[0];
                    if (s_kind == KIND_REPLACE) begin
                        bcast.op = OP_REPLACE;
                    end else begin
                        bcast.op   = OP_REMOVE;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
        if (!accept) begin
            bcast.op   = OP_HOLD;
            count_next = count_reg;
        end
        m_valid_next = accept ? 1'b1 : (m_valid_reg && !m_ready);
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
            entry_t prev_entry, next_entry;
            logic   prev_lt, next_lt;
            logic   cell_valid;

            assign cell_valid = (count_reg > IDX);

            if (i == 0) begin : g_first
                assign prev_entry = '0;
                assign prev_lt    = 1'b1;
            end else begin : g_mid
                assign prev_entry = cell_entry[i-1];
                assign prev_lt    = cell_lt[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign next_entry = '0;
                assign next_lt    = 1'b0;
            end else begin : g_body
                assign next_entry = cell_entry[i+1];
                assign next_lt    = cell_lt[i+1];
            end

            smq_cell u_cell (
                .aclk       (aclk),
                .bcast      (bcast),
                .first_cell ((i == 0) ? 1'b1 : 1'b0),
                .cell_valid (cell_valid),
                .prev_entry (prev_entry),
                .prev_lt    (prev_lt),
                .next_entry (next_entry),
                .next_lt    (next_lt),
                .entry      (cell_entry[i]),
                .lt         (cell_lt[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            head_valid_reg <= head_valid_next;
            out_entry_reg  <= out_entry_next;
            status_reg     <= status_next;
        end
    end

    // occupancy after the request: count_reg once it has been taken
    logic [CNT_W-1:0] occ_reg;
    always_ff @(posedge aclk) begin
        if (accept) begin
            occ_reg <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_head_valid  = head_valid_reg;
    assign m_out_time    = out_entry_reg.event_time;
    assign m_out_code    = out_entry_reg.event_code;
    assign m_out_channel = out_entry_reg.channel;
    assign m_status      = status_reg;
    assign m_occupancy   = occ_reg;

endmodule

`default_nettype wire

// ===== src/smq_cell.sv =====
// ----------------------------------------------------------------------------
// smq_cell
// One slot of the sorted list: compares its entry with the broadcast key and
// takes its own, its neighbor's or the broadcast entry.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_cell
    import smq_pkg::*;
(
    input  wire logic   aclk,
    input  wire bcast_t bcast,
    input  wire logic   first_cell,
    input  wire logic   cell_valid,
    input  wire entry_t prev_entry,
    input  wire logic   prev_lt,
    input  wire entry_t next_entry,
    input  wire logic   next_lt,
    output entry_t      entry,
    output logic        lt
);

    entry_t entry_reg;
    entry_t entry_next;

    // strictly less than the broadcast key (time, then code)
    assign lt = cell_valid &&
                ({entry_reg.event_time, entry_reg.event_code} <
                 {bcast.entry.event_time, bcast.entry.event_code});

    always_comb begin
        entry_next = entry_reg;
        unique case (bcast.op)
            OP_HOLD: begin
                entry_next = entry_reg;
            end
            OP_INSERT: begin
                if (lt) begin
                    entry_next = entry_reg;
                end else if (prev_lt) begin
                    entry_next = bcast.entry;
                end else begin
                    entry_next = prev_entry;
                end
            end
            OP_REMOVE: begin
                entry_next = next_entry;
            end
            OP_REPLACE: begin
                if (next_lt) begin
                    entry_next = next_entry;
                end else if (first_cell || lt) begin
                    entry_next = bcast.entry;
                end else begin
                    entry_next = entry_reg;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== src/smq_checker.sv =====
// ----------------------------------------------------------------------------
// smq_checker
// Port-level checks for the sorted event merge queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_checker
    import smq_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_head_valid,
    input wire logic [TIME_W-1:0] m_out_time,
    input wire logic [STAT_W-1:0] m_status,
    input wire logic [CNT_W-1:0]  m_occupancy
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_time))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("not ready with empty result register");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |->
            !m_head_valid && m_occupancy == CNT_W'(DEPTH))
        else $error("full status with wrong occupancy");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |->
            !m_head_valid && m_occupancy == '0 && m_out_time == '0)
        else $error("empty status with a reported head");

    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_head_valid |-> m_status == ST_OK)
        else $error("head reported with error status");

endmodule

bind sorted_event_merge_queue smq_checker u_smq_checker (.*);

`default_nettype wire

// ===== test/sorted_event_merge_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_event_merge_queue_tb
// Self-checking bench for the sorted event merge queue. A scoreboard keeps its
// own sorted list of heads and predicts every result. Stimulus is a directed
// opening followed by merge rounds and a fill-to-full pass. Both handshakes
// idle at random, except in a stretch where they do not idle at all.
// ----------------------------------------------------------------------------
module sorted_event_merge_queue_tb;
    import smq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                REQ_TARGET  = 650;
    localparam int                IDLE_PCT    = 13;
    localparam int                BIG_ROUND   = 320;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] ev_time;
        logic [CODE_W-1:0] ev_code;
        logic [CHAN_W-1:0] ev_chan;
    } request_t;

    typedef struct packed {
        logic              head_valid;
        logic [TIME_W-1:0] pop_time;
        logic [CODE_W-1:0] pop_code;
        logic [CHAN_W-1:0] pop_channel;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  occupancy;
    } outcome_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind = '0;
    logic [TIME_W-1:0] s_event_time = '0;
    logic [CODE_W-1:0] s_event_code = '0;
    logic [CHAN_W-1:0] s_channel = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_head_valid;
    logic [TIME_W-1:0] m_out_time;
    logic [CODE_W-1:0] m_out_code;
    logic [CHAN_W-1:0] m_out_channel;
    logic [STAT_W-1:0] m_status;
    logic [CNT_W-1:0]  m_occupancy;

    request_t queued_requests[$];
    outcome_t awaited_outcomes[$];
    request_t next_req;

    entry_t   head_list[DEPTH];
    int       head_count = 0;

    int       gen_fill = 0;
    int       live_reqs = 0;
    int       sent_count = 0;
    int       result_count = 0;
    int       pops_seen = 0;
    int       full_drops = 0;
    int       empty_pops = 0;
    int       errors = 0;

    sorted_event_merge_queue u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_event_time  (s_event_time),
        .s_event_code  (s_event_code),
        .s_channel     (s_channel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_head_valid  (m_head_valid),
        .m_out_time    (m_out_time),
        .m_out_code    (m_out_code),
        .m_out_channel (m_out_channel),
        .m_status      (m_status),
        .m_occupancy   (m_occupancy)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scoreboard list: ascending (time, code), new entry ahead of equal keys
    // ------------------------------------------------------------------------
    function automatic void place_head(entry_t e);
        int pos;
        int k;
        pos = 0;
        while (pos < head_count &&
               {head_list[pos].event_time, head_list[pos].event_code} <
               {e.event_time, e.event_code})
            pos++;
        for (k = head_count; k > pos; k--)
            head_list[k] = head_list[k-1];
        head_list[pos] = e;
        head_count++;
    endfunction

    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        entry_t   e;
        int       k;
        o = '0;
        if (r.kind == KIND_INSERT) begin
            if (head_count >= DEPTH) begin
                o.status = ST_FULL;
            end else begin
                e.event_time = r.ev_time;
                e.event_code = r.ev_code;
                e.channel    = r.ev_chan;
                place_head(e);
            end
        end else if (r.kind == KIND_REPLACE || r.kind == KIND_REMOVE) begin
            if (head_count == 0) begin
                o.status = ST_EMPTY;
            end else begin
                e = head_list[0];
                for (k = 1; k < head_count; k++)
                    head_list[k-1] = head_list[k];
                head_count--;
                o.head_valid  = 1'b1;
                o.pop_time    = e.event_time;
                o.pop_code    = e.event_code;
                o.pop_channel = e.channel;
                if (r.kind == KIND_REPLACE) begin
                    e.event_time = r.ev_time;
                    place_head(e);
                end
            end
        end
        o.occupancy = CNT_W'(head_count);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_outcomes.push_back(
                    apply_request({s_kind, s_event_time, s_event_code, s_channel}));
                sent_count++;
            end
            if (!s_valid || s_ready) begin
                if (queued_requests.size() != 0 &&
                    ((sent_count >= 250 && sent_count < 400) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_req = queued_requests.pop_front();
                    s_valid      <= 1'b1;
                    s_kind       <= next_req.kind;
                    s_event_time <= next_req.ev_time;
                    s_event_code <= next_req.ev_code;
                    s_channel    <= next_req.ev_chan;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= (result_count >= 250 && result_count < 400) ||
                   $urandom_range(0, 99) >= IDLE_PCT;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (m_head_valid)
                pops_seen++;
            if (m_status == ST_FULL)
                full_drops++;
            if (m_status == ST_EMPTY)
                empty_pops++;
            if (awaited_outcomes.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                check_field("head_valid", awaited_outcomes[0].head_valid, m_head_valid);
                check_field("out_time", awaited_outcomes[0].pop_time, m_out_time);
                check_field("out_code", awaited_outcomes[0].pop_code, m_out_code);
                check_field("out_channel", awaited_outcomes[0].pop_channel, m_out_channel);
                check_field("status", awaited_outcomes[0].status, m_status);
                check_field("occupancy", awaited_outcomes[0].occupancy, m_occupancy);
                void'(awaited_outcomes.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] rnd_time();
        return TIME_W'($urandom());
    endfunction

    function automatic logic [CODE_W-1:0] rnd_code();
        return CODE_W'($urandom());
    endfunction

    function automatic logic [CHAN_W-1:0] rnd_chan();
        return CHAN_W'($urandom());
    endfunction

    task automatic add_req(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] t,
                           logic [CODE_W-1:0] c, logic [CHAN_W-1:0] ch);
        queued_requests.push_back({kind, t, c, ch});
        if (kind == KIND_INSERT) begin
            if (gen_fill < DEPTH)
                gen_fill++;
        end else if (kind == KIND_REMOVE) begin
            if (gen_fill > 0)
                gen_fill--;
        end
        if (kind != KIND_UNUSED)
            live_reqs++;
    endtask

    task automatic add_noise();
        add_req(KIND_W'($urandom_range(0, 3)), rnd_time(), rnd_code(), rnd_chan());
    endtask

    // load one head per channel, advance the merge by replaces mixed with random requests, then drain
    task automatic merge_round(int nch);
        logic [TIME_W-1:0] now;
        logic [CHAN_W-1:0] base;
        int                span;
        int                n;
        int                i;
        case ($urandom_range(0, 3))
            0: now = '0;
            1: now = 31'h7FFF_FF00;
            default: now = rnd_time();
        endcase
        case ($urandom_range(0, 2))
            0: span = 0;
            1: span = 3;
            default: span = 100000;
        endcase
        base = rnd_chan();
        for (i = 0; i < nch; i++)
            add_req(KIND_INSERT, now + TIME_W'($urandom_range(0, span)),
                    (span < 4) ? CODE_W'($urandom_range(0, 3)) : rnd_code(),
                    base + CHAN_W'(i));
        n = $urandom_range(nch, 3 * nch);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                add_noise();
            end else begin
                now = now + TIME_W'($urandom_range(0, span));
                add_req(KIND_REPLACE, now, rnd_code(), rnd_chan());
            end
        end
        while (gen_fill > 0)
            add_req(KIND_REMOVE, rnd_time(), rnd_code(), rnd_chan());
        if ($urandom_range(0, 1))
            add_req(KIND_W'($urandom_range(1, 2)), rnd_time(), rnd_code(), rnd_chan());
    endtask

    task automatic full_pass();
        int i;
        while (gen_fill < DEPTH)
            add_req(KIND_INSERT, rnd_time(), rnd_code(), rnd_chan());
        add_req(KIND_INSERT, '0, '0, '0);
        add_req(KIND_INSERT, '1, '1, '1);
        add_req(KIND_REPLACE, rnd_time(), rnd_code(), rnd_chan());
        add_req(KIND_INSERT, rnd_time(), rnd_code(), rnd_chan());
        add_req(KIND_REMOVE, rnd_time(), rnd_code(), rnd_chan());
        add_req(KIND_INSERT, rnd_time(), rnd_code(), rnd_chan());
        add_req(KIND_INSERT, rnd_time(), rnd_code(), rnd_chan());
        for (i = 0; i < 6; i++)
            add_req(KIND_REPLACE, rnd_time(), rnd_code(), rnd_chan());
        while (gen_fill > 0)
            add_req(KIND_REMOVE, rnd_time(), rnd_code(), rnd_chan());
    endtask

    initial begin
        int round;
        // empty-queue pops and the unused kind
        add_req(KIND_REMOVE, '1, '1, '1);
        add_req(KIND_REPLACE, '1, '1, '1);
        add_req(KIND_UNUSED, '1, '1, '1);
        // extremes and equal keys
        add_req(KIND_INSERT, '1, '1, '1);
        add_req(KIND_INSERT, '0, '0, '0);
        add_req(KIND_INSERT, '0, '0, 6'd1);
        add_req(KIND_INSERT, 31'd5, 10'd3, 6'd2);
        add_req(KIND_INSERT, 31'd5, 10'd2, 6'd3);
        add_req(KIND_INSERT, 31'd5, 10'd2, 6'd4);
        add_req(KIND_UNUSED, 31'd1, 10'd1, 6'd1);
        // replace ignores code and channel inputs
        add_req(KIND_REPLACE, 31'd5, '1, '1);
        add_req(KIND_REPLACE, '1, 10'd7, 6'd9);
        add_req(KIND_REPLACE, 31'd5, '0, '0);
        add_req(KIND_REMOVE, '0, '0, '0);
        add_req(KIND_REPLACE, 31'd0, '1, '0);
        while (gen_fill > 0)
            add_req(KIND_REMOVE, '0, '0, '0);
        add_req(KIND_REMOVE, '0, '0, '0);

        round = 0;
        while (live_reqs < REQ_TARGET) begin
            if (round == 2)
                full_pass();
            else if ($urandom_range(0, 9) == 0 && live_reqs + BIG_ROUND < REQ_TARGET)
                merge_round($urandom_range(13, 64));
            else
                merge_round($urandom_range(1, 12));
            round++;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_requests.size() != 0 || s_valid || awaited_outcomes.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);

        $display("ran %0d requests: %0d heads popped, %0d inserts dropped at full,",
                 sent_count, pops_seen, full_drops);
        $display("%0d pops on an empty queue", empty_pops);
        if (errors == 0 && awaited_outcomes.size() == 0)
            $display("sorted_event_merge_queue_tb passed");
        else
            $display("sorted_event_merge_queue_tb failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("sorted_event_merge_queue_tb failed");
        $finish;
    end

endmodule
